// ===== hdl/pfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point fragment generator package
// Shared types, constants and register indexes for the point rasterizer.
// ----------------------------------------------------------------------------
package pfg_pkg;

  localparam int MaxPointSize = 8;

  // Sizes are in sixteenths of a pixel, geometry in thirty-seconds.
  localparam logic [7:0] PS_ONE = 8'd16;
  localparam logic [7:0] PS_MAX = 8'(MaxPointSize * 16);

  localparam int CoordW = 21;
  typedef logic signed [CoordW-1:0] coord_t;

  // One whole pixel in thirty-second units.
  localparam coord_t PIX_STEP = coord_t'(32);

  localparam logic [1:0] REG_POINT_SIZE  = 2'd0;
  localparam logic [1:0] REG_SMOOTH_MODE = 2'd1;
  localparam logic [1:0] REG_VIEW_WIDTH  = 2'd2;
  localparam logic [1:0] REG_VIEW_HEIGHT = 2'd3;

  // Classified vertex handed from the front end to the scan engine.
  typedef struct packed {
    logic        single;
    logic        empty;
    logic        smooth;
    logic [7:0]  ps;
    coord_t      cx;
    coord_t      cy;
    coord_t      lox;
    coord_t      hix;
    coord_t      loy;
    coord_t      hiy;
    logic [23:0] depth;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } back_state_t;

endpackage

// ===== hdl/pfg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point fragment generator front end
// Holds the configuration registers and turns a vertex into a clipped square.
// ----------------------------------------------------------------------------
module pfg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  input  logic signed [16:0]   vertex_x,
  input  logic signed [16:0]   vertex_y,
  input  logic [23:0]          vertex_depth,
  output pfg_pkg::entry_t      entry
);

  logic [7:0]  pt_size;
  logic        smooth_mode;
  logic [12:0] view_width;
  logic [12:0] view_height;

  logic [7:0]      ps;
  pfg_pkg::coord_t ps_c;
  pfg_pkg::coord_t cx;
  pfg_pkg::coord_t cy;
  pfg_pkg::coord_t lox;
  pfg_pkg::coord_t hix;
  pfg_pkg::coord_t loy;
  pfg_pkg::coord_t hiy;
  pfg_pkg::coord_t lim_x;
  pfg_pkg::coord_t lim_y;
  pfg_pkg::coord_t clox;
  pfg_pkg::coord_t chix;
  pfg_pkg::coord_t cloy;
  pfg_pkg::coord_t chiy;
  logic            rej;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_size     <= 8'd16;
      smooth_mode <= 1'b0;
      view_width  <= 13'd640;
      view_height <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfg_pkg::REG_POINT_SIZE:  pt_size     <= cfg_data[7:0];
        pfg_pkg::REG_SMOOTH_MODE: smooth_mode <= cfg_data[0];
        pfg_pkg::REG_VIEW_WIDTH:  view_width  <= cfg_data;
        pfg_pkg::REG_VIEW_HEIGHT: view_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ps    = (pt_size > pfg_pkg::PS_MAX) ? pfg_pkg::PS_MAX : pt_size;
    ps_c  = {13'd0, ps};
    cx    = {{3{vertex_x[16]}}, vertex_x, 1'b0};
    cy    = {{3{vertex_y[16]}}, vertex_y, 1'b0};
    lox   = cx - ps_c;
    hix   = cx + ps_c;
    loy   = cy - ps_c;
    hiy   = cy + ps_c;
    lim_x = {3'd0, view_width, 5'd0};
    lim_y = {3'd0, view_height, 5'd0};

    // The limit is never negative, so a low edge at or past it is rejected
    // whether or not it was first clamped to zero.
    clox = (lox < 0) ? '0 : lox;
    chix = (hix > lim_x) ? lim_x : hix;
    cloy = (loy < 0) ? '0 : loy;
    chiy = (hiy > lim_y) ? lim_y : hiy;
    rej  = (lox >= lim_x) || (hix < 0) || (loy >= lim_y) || (hiy < 0);

    entry.single = (pt_size == pfg_pkg::PS_ONE);
    entry.empty  = rej || (clox >= chix) || (cloy >= chiy);
    entry.smooth = smooth_mode;
    entry.ps     = ps;
    entry.cx     = cx;
    entry.cy     = cy;
    entry.lox    = clox;
    entry.hix    = chix;
    entry.loy    = cloy;
    entry.hiy    = chiy;
    entry.depth  = vertex_depth;
  end

endmodule

// ===== hdl/pfg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point fragment generator queue
// Two-entry queue of classified vertices between front end and scan engine.
// ----------------------------------------------------------------------------
module pfg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfg_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output pfg_pkg::entry_t q_data
);

  pfg_pkg::entry_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/pfg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point fragment generator scan engine
// Scans the clipped square one pixel a cycle unless stalled, emits fragments.
// ----------------------------------------------------------------------------
module pfg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pfg_pkg::entry_t     q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  frag_x,
  output logic signed [16:0]  frag_y,
  output logic [23:0]         frag_depth,
  output logic                last_fragment
);

  pfg_pkg::back_state_t state;
  pfg_pkg::back_state_t state_next;

  pfg_pkg::coord_t x;
  pfg_pkg::coord_t y;
  pfg_pkg::coord_t lox;
  pfg_pkg::coord_t hix;
  pfg_pkg::coord_t hiy;
  pfg_pkg::coord_t cx;
  pfg_pkg::coord_t cy;
  logic [15:0]     r2;
  logic            smooth;
  logic [23:0]     depth;

  // A survivor is held back one step so that the final one can carry the
  // last-fragment flag once the scan is known to be over.
  logic               pend_valid;
  logic signed [16:0] pend_x;
  logic signed [16:0] pend_y;

  pfg_pkg::coord_t    dx_full;
  pfg_pkg::coord_t    dy_full;
  logic signed [8:0]  dx;
  logic signed [8:0]  dy;
  logic signed [17:0] sqx;
  logic signed [17:0] sqy;
  logic [16:0]        d2;
  logic               surv;
  logic               out_free;
  logic               advance;
  logic               push_mid;
  logic               push_last;
  pfg_pkg::coord_t    x_step;
  pfg_pkg::coord_t    y_step;
  logic               row_end;
  logic               scan_end;

  always_comb begin
    dx_full   = x - cx;
    dy_full   = y - cy;
    dx        = dx_full[8:0];
    dy        = dy_full[8:0];
    sqx       = dx * dx;
    sqy       = dy * dy;
    d2        = 17'(sqx[15:0]) + 17'(sqy[15:0]);
    surv      = !smooth || (d2 < {1'b0, r2});
    out_free  = !out_valid || !out_stall;
    advance   = !(surv && pend_valid) || out_free;
    x_step    = x + pfg_pkg::PIX_STEP;
    y_step    = y + pfg_pkg::PIX_STEP;
    row_end   = (x_step >= hix);
    scan_end  = row_end && (y_step >= hiy);
    push_mid  = (state == pfg_pkg::ST_RUN) && advance && surv && pend_valid;
    push_last = (state == pfg_pkg::ST_FLUSH) && pend_valid && out_free;
    pop       = (state == pfg_pkg::ST_IDLE) && q_valid;

    state_next = state;
    case (state)
      pfg_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_data.single) begin
            state_next = pfg_pkg::ST_FLUSH;
          end else if (!q_data.empty) begin
            state_next = pfg_pkg::ST_RUN;
          end
        end
      end
      pfg_pkg::ST_RUN: begin
        if (advance && scan_end) begin
          state_next = pfg_pkg::ST_FLUSH;
        end
      end
      pfg_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = pfg_pkg::ST_IDLE;
        end
      end
      default: state_next = pfg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pfg_pkg::ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (push_mid || push_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop && q_data.single) begin
        pend_valid <= 1'b1;
      end else if ((state == pfg_pkg::ST_RUN) && advance && surv) begin
        pend_valid <= 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x      <= q_data.lox;
      y      <= q_data.loy;
      lox    <= q_data.lox;
      hix    <= q_data.hix;
      hiy    <= q_data.hiy;
      cx     <= q_data.cx;
      cy     <= q_data.cy;
      r2     <= q_data.ps * q_data.ps;
      smooth <= q_data.smooth;
      depth  <= q_data.depth;
      if (q_data.single) begin
        pend_x <= q_data.cx[17:1];
        pend_y <= q_data.cy[17:1];
      end
    end else if ((state == pfg_pkg::ST_RUN) && advance) begin
      if (surv) begin
        pend_x <= x[17:1];
        pend_y <= y[17:1];
      end
      if (row_end) begin
        x <= lox;
        y <= y_step;
      end else begin
        x <= x_step;
      end
    end
    if (push_mid || push_last) begin
      frag_x        <= pend_x;
      frag_y        <= pend_y;
      frag_depth    <= depth;
      last_fragment <= push_last;
    end
  end

endmodule

// ===== hdl/point_fragment_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point fragment generator
// Rasterizes one vertex into the fragments covered by a square or round point.
// ----------------------------------------------------------------------------
// Usage: vertices enter on the in channel (in_valid / in_stall) and fragments
// leave on the out channel (out_valid / out_stall); last_fragment marks the
// final fragment of a vertex, and a vertex that covers nothing gives no item
// unless it is of size one. Registers are written on the cfg channel
// (cfg_ready is always high); the user must write them only while the block
// is idle, which the block does not enforce: index 0 point size, 1 smooth
// mode, 2 and 3 viewport. The front end classifies and clips a vertex in the
// cycle it is accepted and places it in a two-entry queue, so in_stall rises
// only when the queue fills. The scan engine takes a vertex from the queue
// and steps one pixel a cycle, unless the out channel holds it, over the
// clipped square, up to 64 pixels for an 8-pixel point. Survivors are held
// one step so the last one can be flagged, and smooth mode drops the pixels
// outside the circle. A stall on the out channel freezes the scan only when
// a fragment is waiting and the output register is still full. Reset
// restores the register defaults (size 1.0, square points, 640 by 480) and
// empties queue and output.
// ----------------------------------------------------------------------------
module point_fragment_generator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [16:0]  vertex_x,
  input  logic signed [16:0]  vertex_y,
  input  logic [23:0]         vertex_depth,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  frag_x,
  output logic signed [16:0]  frag_y,
  output logic [23:0]         frag_depth,
  output logic                last_fragment
);

  pfg_pkg::entry_t entry;
  pfg_pkg::entry_t q_data;
  logic            full;
  logic            q_valid;
  logic            pop;
  logic            push;

  assign in_stall = full;
  assign push     = in_valid && !full;

  pfg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_depth (vertex_depth),
    .entry        (entry)
  );

  pfg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  pfg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frag_x        (frag_x),
    .frag_y        (frag_y),
    .frag_depth    (frag_depth),
    .last_fragment (last_fragment)
  );

endmodule
